### hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

### hw/rtl/cts_pkg.sv
package cts_pkg;

  localparam logic [1:0] MODE_TICK     = 2'd0;
  localparam logic [1:0] MODE_ADD      = 2'd1;
  localparam logic [1:0] MODE_DISPATCH = 2'd2;

  localparam logic [1:0] KIND_ADD_OK   = 2'd0;
  localparam logic [1:0] KIND_ADD_FULL = 2'd1;
  localparam logic [1:0] KIND_RUN      = 2'd2;
  localparam logic [1:0] KIND_IDLE     = 2'd3;

  localparam int MAX_RESULTS = 8;
  localparam int RUN_CNT_W   = $clog2(MAX_RESULTS + 1);

  typedef struct packed {
    logic [15:0] handle;
    logic [15:0] delay;
    logic [15:0] period;
    logic [7:0]  pending;
  } slot_entry_t;

  typedef struct packed {
    logic start;
    logic walk;
    logic finish;
  } cts_cmd_t;

  typedef struct packed {
    logic walk_done;
    logic out_free;
  } cts_sts_t;

endpackage

### hw/rtl/cts_ctrl.sv
module cts_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_mode,
  input  logic [15:0]       in_task_handle,
  input  cts_pkg::cts_sts_t sts,
  output cts_pkg::cts_cmd_t cmd
);
  import cts_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FINISH
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] op_r, op_nxt;
  logic       accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd.start  = accept;
    cmd.walk   = (state_r == ST_WALK);
    cmd.finish = (state_r == ST_FINISH);
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          op_nxt = in_mode;
          if (in_mode == MODE_TICK || in_mode == MODE_DISPATCH) begin
            state_nxt = ST_WALK;
          end else if (in_mode == MODE_ADD) begin
            // a zero handle can never occupy a slot: reject without a search
            state_nxt = (in_task_handle != 16'd0) ? ST_WALK : ST_FINISH;
          end
        end
      end
      ST_WALK: begin
        if (sts.walk_done) begin
          state_nxt = (op_r == MODE_TICK) ? ST_IDLE : ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r    <= MODE_TICK;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

endmodule

### hw/rtl/cts_datapath.sv
module cts_datapath #(
  parameter int SLOT_COUNT = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cts_pkg::cts_cmd_t cmd,
  output cts_pkg::cts_sts_t sts,
  input  logic [1:0]        in_mode,
  input  logic [15:0]       in_task_handle,
  input  logic [15:0]       in_start_delay,
  input  logic [15:0]       in_repeat_period,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_kind,
  output logic [2:0]        out_slot,
  output logic [15:0]       out_run_handle,
  output logic              out_sleep_request,
  output logic              out_last
);
  import cts_pkg::*;

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);

  // slot table
  slot_entry_t           mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] vld_r;

  // latched transaction
  logic [1:0]  op_r;
  logic [15:0] add_handle_r, add_delay_r, add_period_r;

  // walk pipeline: read issue counter and one processing stage
  logic [CNT_W-1:0]     rd_cnt_r;
  logic [IDX_W-1:0]     rd_idx;
  logic                 rd_en;
  slot_entry_t          rd_q_r;
  logic                 rd_vq_r;
  logic                 s_vld_r, s_vld_nxt;
  logic [IDX_W-1:0]     s_idx_r;
  logic                 found_r;
  logic [RUN_CNT_W-1:0] run_cnt_r;

  // held result, sent once the next one is known
  logic        hold_vld_r;
  logic [1:0]  hold_kind_r;
  logic [2:0]  hold_slot_r;
  logic [15:0] hold_handle_r;

  logic        out_vld_r;
  logic [1:0]  out_kind_r;
  logic [2:0]  out_slot_r;
  logic [15:0] out_handle_r;
  logic        out_sleep_r, out_last_r;

  slot_entry_t ent, wr_ent;
  logic        wr_en, go, emit_run, found_set, out_free, push;
  logic [1:0]  push_kind;
  logic [2:0]  push_slot;
  logic [15:0] push_handle;
  logic        push_sleep, push_last;
  logic        walk_end;

  assign rd_idx   = rd_cnt_r[IDX_W-1:0];
  assign ent      = rd_vq_r ? rd_q_r : '0;
  assign out_free = !out_vld_r || out_ready;
  assign walk_end = found_r || (rd_cnt_r == CNT_W'(SLOT_COUNT) && !s_vld_r);

  always_comb begin
    sts.walk_done = cmd.walk && walk_end;
    sts.out_free  = out_free;
  end

  // process the slot in the stage
  always_comb begin
    wr_en     = 1'b0;
    wr_ent    = ent;
    go        = 1'b0;
    emit_run  = 1'b0;
    found_set = 1'b0;
    if (cmd.walk && s_vld_r && !found_r) begin
      unique case (op_r)
        MODE_TICK: begin
          go    = 1'b1;
          wr_en = 1'b1;
          if (ent.handle != 16'd0) begin
            if (ent.delay == 16'd0) begin
              if (ent.pending != 8'hFF) begin
                wr_ent.pending = ent.pending + 8'd1;
              end
              if (ent.period != 16'd0) begin
                wr_ent.delay = ent.period;
              end
            end else begin
              wr_ent.delay = ent.delay - 16'd1;
            end
          end
        end
        MODE_ADD: begin
          go = 1'b1;
          if (ent.handle == 16'd0) begin
            wr_en     = 1'b1;
            found_set = 1'b1;
            wr_ent    = '{handle: add_handle_r, delay: add_delay_r,
                          period: add_period_r, pending: 8'd0};
          end
        end
        MODE_DISPATCH: begin
          if (ent.pending != 8'd0 && run_cnt_r != RUN_CNT_W'(MAX_RESULTS)) begin
            emit_run = 1'b1;
            // hold the stage until the previous result can move out
            if (!hold_vld_r || out_free) begin
              go    = 1'b1;
              wr_en = 1'b1;
              if (ent.period == 16'd0) begin
                wr_ent = '0;
              end else begin
                wr_ent.pending = ent.pending - 8'd1;
              end
            end
          end else begin
            go = 1'b1;
          end
        end
        default: go = 1'b1;
      endcase
    end
  end

  assign rd_en = cmd.walk && !found_r && !found_set &&
                 (rd_cnt_r != CNT_W'(SLOT_COUNT)) && (!s_vld_r || go);

  always_comb begin
    priority if (cmd.start || found_set) begin
      s_vld_nxt = 1'b0;
    end else if (rd_en) begin
      s_vld_nxt = 1'b1;
    end else if (go) begin
      s_vld_nxt = 1'b0;
    end else begin
      s_vld_nxt = s_vld_r;
    end
  end

  // output register feed
  always_comb begin
    push        = 1'b0;
    push_kind   = hold_kind_r;
    push_slot   = hold_slot_r;
    push_handle = hold_handle_r;
    push_sleep  = 1'b0;
    push_last   = 1'b0;
    if (cmd.finish) begin
      push      = out_free;
      push_last = 1'b1;
      push_sleep = (op_r == MODE_DISPATCH);
      if (!hold_vld_r) begin
        push_kind   = (op_r == MODE_DISPATCH) ? KIND_IDLE : KIND_ADD_FULL;
        push_slot   = 3'd0;
        push_handle = 16'd0;
      end
    end else if (emit_run && go && hold_vld_r) begin
      push = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s_idx_r] <= wr_ent;
    end
    if (rd_en) begin
      rd_q_r  <= mem[rd_idx];
      rd_vq_r <= vld_r[rd_idx];
      s_idx_r <= rd_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= '0;
      rd_cnt_r   <= '0;
      s_vld_r    <= 1'b0;
      found_r    <= 1'b0;
      run_cnt_r  <= '0;
      hold_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[s_idx_r] <= 1'b1;
      end
      s_vld_r <= s_vld_nxt;
      if (cmd.start) begin
        rd_cnt_r   <= '0;
        found_r    <= 1'b0;
        run_cnt_r  <= '0;
        hold_vld_r <= 1'b0;
      end else begin
        if (rd_en) begin
          rd_cnt_r <= rd_cnt_r + CNT_W'(1);
        end
        if (found_set) begin
          found_r    <= 1'b1;
          hold_vld_r <= 1'b1;
        end
        if (emit_run && go) begin
          run_cnt_r  <= run_cnt_r + RUN_CNT_W'(1);
          hold_vld_r <= 1'b1;
        end
      end
      if (push) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r         <= in_mode;
      add_handle_r <= in_task_handle;
      add_delay_r  <= in_start_delay;
      add_period_r <= in_repeat_period;
    end
    if (found_set) begin
      hold_kind_r   <= KIND_ADD_OK;
      hold_slot_r   <= 3'(s_idx_r);
      hold_handle_r <= 16'd0;
    end else if (emit_run && go) begin
      hold_kind_r   <= KIND_RUN;
      hold_slot_r   <= 3'(s_idx_r);
      hold_handle_r <= ent.handle;
    end
    if (push) begin
      out_kind_r   <= push_kind;
      out_slot_r   <= push_slot;
      out_handle_r <= push_handle;
      out_sleep_r  <= push_sleep;
      out_last_r   <= push_last;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_kind          = out_kind_r;
  assign out_slot          = out_slot_r;
  assign out_run_handle    = out_handle_r;
  assign out_sleep_request = out_sleep_r;
  assign out_last          = out_last_r;

endmodule

### hw/rtl/cooperative_task_scheduler.sv
// Cooperative task scheduler with a table of SLOT_COUNT task slots.
// Input channel (in_valid/in_ready) carries one command per transaction:
//   tick (age every occupied slot), add (place a task in the lowest free
//   slot) or dispatch (emit a run result for each slot with pending runs).
// Result channel (out_valid/out_ready) carries the results; out_last marks
//   the final result of a command, out_sleep_request the final one of a
//   dispatch. Tick gives no result; add gives one; dispatch gives one to
//   eight.
// Timing: a command walks the slot table one slot per cycle through a table
//   with registered read, except while a dispatch result waits for the
//   receiver; an add stops at the first free slot. in_ready is high only
//   between commands.
// The walk pauses while a dispatch result waits for the receiver; one result
//   is held inside and one sits in the output register, so a stalled
//   receiver never loses or repeats a result.
// Reset (rst_n low, synchronous) frees every slot at once through per-slot
//   valid bits; no clearing pass is needed.
module cooperative_task_scheduler #(
  parameter int SLOT_COUNT = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [15:0] in_task_handle,
  input  logic [15:0] in_start_delay,
  input  logic [15:0] in_repeat_period,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [2:0]  out_slot,
  output logic [15:0] out_run_handle,
  output logic        out_sleep_request,
  output logic        out_last
);
  import cts_pkg::*;

  `include "assert_macros.svh"

  cts_cmd_t cmd;
  cts_sts_t sts;

  cts_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_task_handle (in_task_handle),
    .sts            (sts),
    .cmd            (cmd)
  );

  cts_datapath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_mode           (in_mode),
    .in_task_handle    (in_task_handle),
    .in_start_delay    (in_start_delay),
    .in_repeat_period  (in_repeat_period),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_slot          (out_slot),
    .out_run_handle    (out_run_handle),
    .out_sleep_request (out_sleep_request),
    .out_last          (out_last)
  );

  `ASSERT_NEVER(a_ready_while_busy, clk, rst_n, in_ready && (cmd.walk || cmd.finish))
  `ASSERT_CLK(a_busy_after_accept, clk, rst_n,
              (in_valid && in_ready && (in_mode == MODE_TICK || in_mode == MODE_ADD ||
               in_mode == MODE_DISPATCH)) |=> !in_ready)
  `ASSERT_CLK(a_finish_sends_last, clk, rst_n,
              (cmd.finish && sts.out_free) |=> (out_valid && out_last))

endmodule

### tb/sv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cts_pkg::*;

  localparam int SLOTS = 8;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam longint WATCHDOG_NS = 64'd8_000_000;

  typedef struct {
    logic [1:0]  kind;
    logic [2:0]  slot;
    logic [15:0] handle;
    logic        sleep;
    logic        last;
  } sched_result_t;

  class sched_scoreboard;
    logic [15:0] tbl_handle [SLOTS];
    logic [15:0] tbl_delay [SLOTS];
    logic [15:0] tbl_period [SLOTS];
    logic [7:0]  tbl_pending [SLOTS];
    sched_result_t due_results [$];
    int commands;
    int checked;
    int runs;
    int idles;
    int rejects;
    int failures;

    function new();
      for (int i = 0; i < SLOTS; i++) free_entry(i);
      commands = 0;
      checked = 0;
      runs = 0;
      idles = 0;
      rejects = 0;
      failures = 0;
    endfunction

    function void free_entry(int i);
      tbl_handle[i] = '0;
      tbl_delay[i] = '0;
      tbl_period[i] = '0;
      tbl_pending[i] = '0;
    endfunction

    // Slots that will not be freed any time soon: periodic or far in the future.
    function int parked_slots();
      int n;
      n = 0;
      for (int i = 0; i < SLOTS; i++)
        if (tbl_handle[i] != 0 && (tbl_period[i] != 0 || tbl_delay[i] > 64)) n++;
      return n;
    endfunction

    function int outstanding();
      return due_results.size();
    endfunction

    function void push_result(logic [1:0] kind, logic [2:0] slot, logic [15:0] handle,
                              logic sleep, logic last);
      sched_result_t r;
      r.kind = kind;
      r.slot = slot;
      r.handle = handle;
      r.sleep = sleep;
      r.last = last;
      due_results.push_back(r);
    endfunction

    // Update the task table for one accepted command and queue its results.
    function void apply_command(logic [1:0] mode, logic [15:0] h, logic [15:0] d,
                                logic [15:0] p);
      int n;
      bit placed;
      commands++;
      case (mode)
        MODE_TICK: begin
          for (int i = 0; i < SLOTS; i++) begin
            if (tbl_handle[i] != 0) begin
              if (tbl_delay[i] == 0) begin
                if (tbl_pending[i] != 8'hFF) tbl_pending[i]++;
                if (tbl_period[i] != 0) tbl_delay[i] = tbl_period[i];
              end else begin
                tbl_delay[i]--;
              end
            end
          end
        end
        MODE_ADD: begin
          placed = 1'b0;
          if (h != 0) begin
            for (int i = 0; i < SLOTS && !placed; i++) begin
              if (tbl_handle[i] == 0) begin
                tbl_handle[i] = h;
                tbl_delay[i] = d;
                tbl_period[i] = p;
                tbl_pending[i] = '0;
                push_result(KIND_ADD_OK, 3'(i), 16'h0, 1'b0, 1'b1);
                placed = 1'b1;
              end
            end
          end
          if (!placed) push_result(KIND_ADD_FULL, 3'd0, 16'h0, 1'b0, 1'b1);
        end
        MODE_DISPATCH: begin
          n = 0;
          for (int i = 0; i < SLOTS && n < MAX_RESULTS; i++) begin
            if (tbl_pending[i] != 0) begin
              push_result(KIND_RUN, 3'(i), tbl_handle[i], 1'b0, 1'b0);
              n++;
              tbl_pending[i]--;
              if (tbl_period[i] == 0) free_entry(i);
            end
          end
          if (n == 0) begin
            push_result(KIND_IDLE, 3'd0, 16'h0, 1'b1, 1'b1);
          end else begin
            due_results[due_results.size() - 1].sleep = 1'b1;
            due_results[due_results.size() - 1].last = 1'b1;
          end
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        failures++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(logic [1:0] kind, logic [2:0] slot, logic [15:0] handle,
                               logic sleep, logic last);
      sched_result_t want;
      if (due_results.size() == 0) begin
        failures++;
        $display("%0t: unexpected result, expected none, actual kind %0d slot %0d handle %0h",
                 $time, kind, slot, handle);
        return;
      end
      want = due_results.pop_front();
      checked++;
      compare_field("kind", want.kind, kind);
      compare_field("slot", want.slot, slot);
      compare_field("run_handle", want.handle, handle);
      compare_field("sleep_request", want.sleep, sleep);
      compare_field("last", want.last, last);
      case (want.kind)
        KIND_RUN: runs++;
        KIND_IDLE: idles++;
        KIND_ADD_FULL: rejects++;
        default: ;
      endcase
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_mode = MODE_TICK;
  logic [15:0] in_task_handle = '0;
  logic [15:0] in_start_delay = '0;
  logic [15:0] in_repeat_period = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_kind;
  logic [2:0]  out_slot;
  logic [15:0] out_run_handle;
  logic        out_sleep_request;
  logic        out_last;

  int idle_pct = 0;
  int stall_pct = 0;
  int hold_cycles = 0;

  sched_scoreboard sb;

  cooperative_task_scheduler i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_task_handle   (in_task_handle),
    .in_start_delay   (in_start_delay),
    .in_repeat_period (in_repeat_period),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_slot         (out_slot),
    .out_run_handle   (out_run_handle),
    .out_sleep_request(out_sleep_request),
    .out_last         (out_last)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #(WATCHDOG_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Receiver: check each result transaction, stall at random or hold off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready)
        sb.check_result(out_kind, out_slot, out_run_handle, out_sleep_request, out_last);
      if (hold_cycles != 0) begin
        out_ready <= 1'b0;
        hold_cycles <= hold_cycles - 1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  task automatic send_command(input logic [1:0] mode, input logic [15:0] h,
                              input logic [15:0] d, input logic [15:0] p);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_task_handle <= h;
    in_start_delay <= d;
    in_repeat_period <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.apply_command(mode, h, d, p);
  endtask

  // Mostly ticks, adds and dispatches; keep few long-lived tasks so slots keep cycling.
  task automatic random_command(output bit counted);
    logic [1:0]  mode;
    logic [15:0] h;
    logic [15:0] d;
    logic [15:0] p;
    int r;
    r = $urandom_range(0, 99);
    h = 16'($urandom);
    d = 16'($urandom);
    p = 16'($urandom);
    if (r < 44) mode = MODE_TICK;
    else if (r < 70) mode = MODE_ADD;
    else if (r < 95) mode = MODE_DISPATCH;
    else mode = MODE_UNUSED;
    if (mode == MODE_ADD) begin
      h = 16'($urandom_range(1, 65535));
      if ($urandom_range(0, 99) < 3) h = 16'h0;
      if (sb.parked_slots() >= 5 || $urandom_range(0, 9) != 0)
        d = 16'($urandom_range(0, 6));
      if (sb.parked_slots() >= 5 || $urandom_range(0, 9) >= 2) p = 16'h0;
      else if ($urandom_range(0, 1) == 1) p = 16'($urandom_range(1, 4));
    end
    send_command(mode, h, d, p);
    counted = (mode != MODE_UNUSED);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int n;
    bit counted;
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty dispatch, zero handle, field extremes, full table, unused mode.
    send_command(MODE_DISPATCH, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_command(MODE_ADD, 16'h0000, 16'h0005, 16'h0000);
    send_command(MODE_ADD, 16'hFFFF, 16'h0000, 16'h0000);
    send_command(MODE_ADD, 16'h0001, 16'h0001, 16'h0000);
    send_command(MODE_ADD, 16'h8000, 16'h0000, 16'hFFFF);
    send_command(MODE_ADD, 16'h7FFF, 16'hFFFF, 16'h0000);
    send_command(MODE_ADD, 16'h00A5, 16'h0002, 16'h0000);
    send_command(MODE_ADD, 16'h5A00, 16'h0000, 16'h0000);
    send_command(MODE_ADD, 16'h0F0F, 16'h0000, 16'h0002);
    send_command(MODE_ADD, 16'hF0F0, 16'h0003, 16'h0000);
    send_command(MODE_ADD, 16'h1111, 16'h0000, 16'h0000);
    send_command(MODE_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_command(MODE_TICK, 16'h0000, 16'h0000, 16'h0000);
    send_command(MODE_DISPATCH, 16'h0000, 16'h0000, 16'h0000);
    repeat (4) send_command(MODE_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_command(MODE_DISPATCH, 16'h0000, 16'h0000, 16'h0000);
    send_command(MODE_DISPATCH, 16'h0000, 16'h0000, 16'h0000);
    send_command(MODE_ADD, 16'hC3C3, 16'h0000, 16'h0001);
    send_command(MODE_TICK, 16'h0000, 16'h0000, 16'h0000);
    send_command(MODE_TICK, 16'h0000, 16'h0000, 16'h0000);
    send_command(MODE_DISPATCH, 16'h0000, 16'h0000, 16'h0000);
    settle();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 82; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 82; end
        default: begin idle_pct = 34; stall_pct <= 34; end
      endcase
      n = 0;
      while (n < 30) begin
        random_command(counted);
        if (counted) n++;
        // Hold off the receiver while commands keep coming, so the block backs up.
        if (phase == 0 && n == 8 && counted) begin
          hold_cycles <= HOLD_OFF_CYCLES;
          repeat (24) begin
            random_command(counted);
            if (counted) n++;
          end
        end
        if (phase == 3 && n == 15 && counted) settle();
      end
      settle();
    end

    // Flush short one-shots, then tick a one-shot task with no delay past its
    // pending ceiling: a wrapped count would dispatch idle instead of a run.
    idle_pct = 0;
    stall_pct <= 0;
    repeat (8) send_command(MODE_TICK, 16'h0000, 16'h0000, 16'h0000);
    send_command(MODE_DISPATCH, 16'h0000, 16'h0000, 16'h0000);
    send_command(MODE_ADD, 16'h5A5A, 16'h0000, 16'h0000);
    repeat (256) send_command(MODE_TICK, 16'($urandom), 16'($urandom), 16'($urandom));
    send_command(MODE_DISPATCH, 16'h0000, 16'h0000, 16'h0000);
    settle();

    $display("Ran %0d commands (directed, four idle/stall mixes, receiver hold-off, %s",
             sb.commands, "pending-run saturation).");
    $display("Checked %0d results: %0d runs, %0d idle, %0d rejected adds, %0d mismatches.",
             sb.checked, sb.runs, sb.idles, sb.rejects, sb.failures);
    if (sb.failures == 0 && sb.outstanding() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
